// ===== design/tmsc_pkg.sv =====
// Package for the triangle map stretch check.
// Shared constants, register map and controller/datapath command types.
// No dependencies.
package tmsc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NORM_BITS = 14;
  localparam int DEGEN_EXP = 41;
  localparam int DEGEN_KMAX = 67;
  localparam int RATIO_FRAC_SHIFT = 7;

  localparam logic [15:0] RATIO_ONE = 16'd256;
  localparam logic [15:0] RATIO_SAT = 16'hFFFF;
  localparam logic [15:0] MAX_STRETCH_RESET = 16'd1024;

  localparam int MAC_STEPS = 35;
  localparam int SQRT_ITERS = 64;
  localparam int DIV_BITS = 16;
  localparam int CNT_W = $clog2(SQRT_ITERS);
  localparam int MAC_IDX_W = $clog2(MAC_STEPS);
  localparam int DIV_IDX_W = $clog2(DIV_BITS);

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_MAX_STRETCH = '0;

  typedef struct packed {
    logic                 take_src;
    logic                 take_map;
    logic                 norm_step;
    logic                 mac_step;
    logic [MAC_IDX_W-1:0] mac_idx;
    logic                 sqrt_init;
    logic                 sqrt_sel;
    logic                 sqrt_step;
    logic                 q_load;
    logic                 div_init;
    logic                 div_step;
    logic [DIV_IDX_W-1:0] div_bit;
    logic                 res_load;
  } tmsc_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic det_bad;
  } tmsc_sts_t;

endpackage

// ===== design/tmsc_datapath.sv =====
// Datapath of the triangle map stretch check: edge store, normalizer, shared MAC,
// shared square root unit, ratio divider and result register.
// Depends on tmsc_pkg.
module tmsc_datapath #(
  parameter int COORD_WIDTH = tmsc_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tmsc_pkg::tmsc_cmd_t      cmd,
  output tmsc_pkg::tmsc_sts_t      sts,
  input  logic [9*COORD_WIDTH-1:0] coords,
  input  logic [15:0]              max_stretch_ratio,
  output logic                     stretched,
  output logic [15:0]              stretch_ratio,
  output logic                     degenerate
);
  import tmsc_pkg::*;

  localparam int EW  = COORD_WIDTH + 1;
  localparam int NW  = NORM_BITS + 1;
  localparam int SHW = $clog2(EW);
  localparam int KW  = SHW + 3;
  localparam int MW  = 32;
  localparam int PW  = 2 * MW;
  localparam int HW  = MW - 1;
  localparam int AW  = 128;
  localparam int QW  = 64;
  localparam int RW  = QW + 3;
  localparam int DRW = QW + DIV_BITS;

  typedef enum logic [4:0] {
    SRC_A0, SRC_A1, SRC_A2, SRC_A3, SRC_A4, SRC_A5,
    SRC_B0, SRC_B1, SRC_B2, SRC_B3, SRC_B4, SRC_B5,
    SRC_G11, SRC_G12, SRC_G22, SRC_C11, SRC_C12, SRC_C22,
    SRC_TLO, SRC_THI, SRC_ALO, SRC_AHI, SRC_CLO, SRC_CHI
  } opnd_t;
  typedef enum logic [1:0] {ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB} acc_mode_t;
  typedef enum logic [2:0] {SH_0, SH_1, SH_31, SH_32, SH_62} sh_t;
  typedef enum logic [3:0] {
    DST_NONE, DST_G11, DST_G12, DST_G22, DST_C11, DST_C12, DST_C22,
    DST_ADET, DST_CDET, DST_TR, DST_T2, DST_AC
  } dst_t;
  typedef struct packed {
    opnd_t     a;
    opnd_t     b;
    acc_mode_t mode;
    sh_t       sh;
    dst_t      dst;
  } mac_op_t;

  function automatic logic [EW-1:0] mag_of(input logic signed [EW-1:0] e);
    return e[EW-1] ? EW'(-e) : EW'(e);
  endfunction

  // step table of the multiply-accumulate sequence
  function automatic mac_op_t mac_op(input logic [MAC_IDX_W-1:0] idx);
    mac_op_t op;
    op = '{SRC_A0, SRC_A0, ACC_NOP, SH_0, DST_NONE};
    unique case (idx)
      6'd0:  op = '{SRC_A0, SRC_A0, ACC_LOAD, SH_0, DST_NONE};
      6'd1:  op = '{SRC_A1, SRC_A1, ACC_ADD, SH_0, DST_NONE};
      6'd2:  op = '{SRC_A2, SRC_A2, ACC_ADD, SH_0, DST_G11};
      6'd3:  op = '{SRC_A0, SRC_A3, ACC_LOAD, SH_0, DST_NONE};
      6'd4:  op = '{SRC_A1, SRC_A4, ACC_ADD, SH_0, DST_NONE};
      6'd5:  op = '{SRC_A2, SRC_A5, ACC_ADD, SH_0, DST_G12};
      6'd6:  op = '{SRC_A3, SRC_A3, ACC_LOAD, SH_0, DST_NONE};
      6'd7:  op = '{SRC_A4, SRC_A4, ACC_ADD, SH_0, DST_NONE};
      6'd8:  op = '{SRC_A5, SRC_A5, ACC_ADD, SH_0, DST_G22};
      6'd9:  op = '{SRC_B0, SRC_B0, ACC_LOAD, SH_0, DST_NONE};
      6'd10: op = '{SRC_B1, SRC_B1, ACC_ADD, SH_0, DST_NONE};
      6'd11: op = '{SRC_B2, SRC_B2, ACC_ADD, SH_0, DST_C11};
      6'd12: op = '{SRC_B0, SRC_B3, ACC_LOAD, SH_0, DST_NONE};
      6'd13: op = '{SRC_B1, SRC_B4, ACC_ADD, SH_0, DST_NONE};
      6'd14: op = '{SRC_B2, SRC_B5, ACC_ADD, SH_0, DST_C12};
      6'd15: op = '{SRC_B3, SRC_B3, ACC_LOAD, SH_0, DST_NONE};
      6'd16: op = '{SRC_B4, SRC_B4, ACC_ADD, SH_0, DST_NONE};
      6'd17: op = '{SRC_B5, SRC_B5, ACC_ADD, SH_0, DST_C22};
      6'd19: op = '{SRC_C11, SRC_C22, ACC_LOAD, SH_0, DST_NONE};
      6'd20: op = '{SRC_C12, SRC_C12, ACC_SUB, SH_0, DST_ADET};
      6'd21: op = '{SRC_G11, SRC_G22, ACC_LOAD, SH_0, DST_NONE};
      6'd22: op = '{SRC_G12, SRC_G12, ACC_SUB, SH_0, DST_CDET};
      6'd23: op = '{SRC_C22, SRC_G11, ACC_LOAD, SH_0, DST_NONE};
      6'd24: op = '{SRC_C12, SRC_G12, ACC_SUB, SH_1, DST_NONE};
      6'd25: op = '{SRC_C11, SRC_G22, ACC_ADD, SH_0, DST_TR};
      6'd27: op = '{SRC_TLO, SRC_TLO, ACC_LOAD, SH_0, DST_NONE};
      6'd28: op = '{SRC_THI, SRC_TLO, ACC_ADD, SH_32, DST_NONE};
      6'd29: op = '{SRC_THI, SRC_THI, ACC_ADD, SH_62, DST_T2};
      6'd30: op = '{SRC_ALO, SRC_CLO, ACC_LOAD, SH_0, DST_NONE};
      6'd31: op = '{SRC_ALO, SRC_CHI, ACC_ADD, SH_31, DST_NONE};
      6'd32: op = '{SRC_AHI, SRC_CLO, ACC_ADD, SH_31, DST_NONE};
      6'd33: op = '{SRC_AHI, SRC_CHI, ACC_ADD, SH_62, DST_AC};
      default: op = '{SRC_A0, SRC_A0, ACC_NOP, SH_0, DST_NONE};
    endcase
    return op;
  endfunction

  logic signed [COORD_WIDTH-1:0] vtx [9];
  logic signed [EW-1:0] edge_new [6];
  logic signed [EW-1:0] src_e [6];
  logic [EW-1:0] wa_mag [6];
  logic [EW-1:0] wb_mag [6];
  logic [5:0] wa_neg, wb_neg;
  logic [SHW-1:0] ss, sm;
  logic [EW-1:0] or_a, or_b;
  logic a_big, b_big;
  logic signed [NW-1:0] na [6];
  logic signed [NW-1:0] nb [6];

  logic signed [31:0] g11, g12, g22, c11, c12, c22;
  logic signed [63:0] adet, cdet, tr;
  logic [AW-1:0] t2, ac;
  logic [63:0] trc;

  mac_op_t op_cur;
  logic signed [MW-1:0] opa, opb;
  logic signed [PW-1:0] prod;
  acc_mode_t p_mode;
  sh_t p_sh;
  dst_t p_dst;
  logic p_vld;
  logic signed [AW-1:0] prod_ext, prod_sh, acc, acc_next;

  logic [AW-1:0] ac4, disc;
  logic [AW-1:0] sq_x;
  logic [RW-1:0] sq_rem, rem_sh, sq_trial;
  logic [QW-1:0] sq_root, q;
  logic [DRW-1:0] drem, dtrial;
  logic [15:0] ratio;

  logic signed [KW-1:0] kval;
  logic [KW-1:0] lsh, rsh;
  logic [AW-1:0] lhs, rhs;
  logic degen_calc, degen_eff, str_eff;
  logic [15:0] ratio_eff;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      vtx[i] = coords[i*COORD_WIDTH +: COORD_WIDTH];
    end
    for (int i = 0; i < 3; i++) begin
      edge_new[i]   = EW'(vtx[3+i]) - EW'(vtx[i]);
      edge_new[3+i] = EW'(vtx[6+i]) - EW'(vtx[i]);
    end
  end

  always_comb begin
    or_a = '0;
    or_b = '0;
    for (int i = 0; i < 6; i++) begin
      or_a = or_a | wa_mag[i];
      or_b = or_b | wb_mag[i];
      na[i] = wa_neg[i] ? -$signed({1'b0, wa_mag[i][NORM_BITS-1:0]})
                        : $signed({1'b0, wa_mag[i][NORM_BITS-1:0]});
      nb[i] = wb_neg[i] ? -$signed({1'b0, wb_mag[i][NORM_BITS-1:0]})
                        : $signed({1'b0, wb_mag[i][NORM_BITS-1:0]});
    end
    a_big = |or_a[EW-1:NORM_BITS];
    b_big = |or_b[EW-1:NORM_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) src_e[i] <= '0;
    end else if (cmd.take_src) begin
      for (int i = 0; i < 6; i++) src_e[i] <= edge_new[i];
    end
  end

  // shift right one bit a cycle until every magnitude fits NORM_BITS
  always_ff @(posedge clk) begin
    if (cmd.take_map) begin
      for (int i = 0; i < 6; i++) begin
        wa_mag[i] <= mag_of(src_e[i]);
        wa_neg[i] <= src_e[i][EW-1];
        wb_mag[i] <= mag_of(edge_new[i]);
        wb_neg[i] <= edge_new[i][EW-1];
      end
      ss <= '0;
      sm <= '0;
    end else if (cmd.norm_step) begin
      if (a_big) begin
        for (int i = 0; i < 6; i++) wa_mag[i] <= wa_mag[i] >> 1;
        ss <= ss + 1'b1;
      end
      if (b_big) begin
        for (int i = 0; i < 6; i++) wb_mag[i] <= wb_mag[i] >> 1;
        sm <= sm + 1'b1;
      end
    end
  end

  assign trc = tr[63] ? '0 : 64'(tr);

  function automatic logic signed [MW-1:0] opnd_val(input opnd_t s);
    logic signed [MW-1:0] v;
    unique case (s)
      SRC_A0:  v = MW'(na[0]);
      SRC_A1:  v = MW'(na[1]);
      SRC_A2:  v = MW'(na[2]);
      SRC_A3:  v = MW'(na[3]);
      SRC_A4:  v = MW'(na[4]);
      SRC_A5:  v = MW'(na[5]);
      SRC_B0:  v = MW'(nb[0]);
      SRC_B1:  v = MW'(nb[1]);
      SRC_B2:  v = MW'(nb[2]);
      SRC_B3:  v = MW'(nb[3]);
      SRC_B4:  v = MW'(nb[4]);
      SRC_B5:  v = MW'(nb[5]);
      SRC_G11: v = g11;
      SRC_G12: v = g12;
      SRC_G22: v = g22;
      SRC_C11: v = c11;
      SRC_C12: v = c12;
      SRC_C22: v = c22;
      SRC_TLO: v = $signed({1'b0, trc[HW-1:0]});
      SRC_THI: v = $signed({1'b0, trc[2*HW-1:HW]});
      SRC_ALO: v = $signed({1'b0, adet[HW-1:0]});
      SRC_AHI: v = $signed({1'b0, adet[2*HW-1:HW]});
      SRC_CLO: v = $signed({1'b0, cdet[HW-1:0]});
      SRC_CHI: v = $signed({1'b0, cdet[2*HW-1:HW]});
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op_cur = mac_op(cmd.mac_idx);
    opa = opnd_val(op_cur.a);
    opb = opnd_val(op_cur.b);
  end

  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else p_vld <= cmd.mac_step;
    if (cmd.mac_step) begin
      prod <= opa * opb;
      p_mode <= op_cur.mode;
      p_sh <= op_cur.sh;
      p_dst <= op_cur.dst;
    end
  end

  always_comb begin
    prod_ext = AW'(prod);
    unique case (p_sh)
      SH_0:    prod_sh = prod_ext;
      SH_1:    prod_sh = prod_ext <<< 1;
      SH_31:   prod_sh = prod_ext <<< HW;
      SH_32:   prod_sh = prod_ext <<< (HW + 1);
      SH_62:   prod_sh = prod_ext <<< (2 * HW);
      default: prod_sh = prod_ext;
    endcase
    unique case (p_mode)
      ACC_LOAD: acc_next = prod_sh;
      ACC_ADD:  acc_next = acc + prod_sh;
      ACC_SUB:  acc_next = acc - prod_sh;
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_vld) begin
      acc <= acc_next;
      unique case (p_dst)
        DST_G11:  g11 <= acc_next[31:0];
        DST_G12:  g12 <= acc_next[31:0];
        DST_G22:  g22 <= acc_next[31:0];
        DST_C11:  c11 <= acc_next[31:0];
        DST_C12:  c12 <= acc_next[31:0];
        DST_C22:  c22 <= acc_next[31:0];
        DST_ADET: adet <= acc_next[63:0];
        DST_CDET: cdet <= acc_next[63:0];
        DST_TR:   tr <= acc_next[63:0];
        DST_T2:   t2 <= acc_next;
        DST_AC:   ac <= acc_next;
        default:  ;
      endcase
    end
  end

  assign sts.norm_done = !a_big && !b_big;
  assign sts.det_bad = adet[63] || (adet == '0) || cdet[63] || (cdet == '0);

  always_comb begin
    ac4 = {ac[AW-3:0], 2'b00};
    disc = (ac4 <= t2) ? (t2 - ac4) : '0;
  end

  // digit-by-digit square root, two radicand bits a step
  always_comb begin
    rem_sh = {sq_rem[RW-3:0], sq_x[AW-1:AW-2]};
    sq_trial = RW'({sq_root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_x <= cmd.sqrt_sel ? ac : disc;
      sq_rem <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step) begin
      sq_x <= {sq_x[AW-3:0], 2'b00};
      if (rem_sh >= sq_trial) begin
        sq_rem <= rem_sh - sq_trial;
        sq_root <= {sq_root[QW-2:0], 1'b1};
      end else begin
        sq_rem <= rem_sh;
        sq_root <= {sq_root[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_load) q <= trc + sq_root;
  end

  // restoring divide of 128*Q by S, one quotient bit a step, 16 bits saturate
  assign dtrial = DRW'(sq_root) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem <= DRW'({q, RATIO_FRAC_SHIFT'(0)});
      ratio <= '0;
    end else if (cmd.div_step) begin
      if (drem >= dtrial) begin
        drem <= drem - dtrial;
        ratio[cmd.div_bit] <= 1'b1;
      end
    end
  end

  // sigma2 below 2^-20: Cd * 2^k < Q
  always_comb begin
    kval = $signed(KW'({ss, 1'b0})) - $signed(KW'({sm, 1'b0})) + KW'(DEGEN_EXP);
    lsh = kval[KW-1] ? '0 : KW'(kval);
    rsh = kval[KW-1] ? KW'(-kval) : '0;
    lhs = AW'(64'(cdet)) << lsh;
    rhs = AW'(q) << rsh;
    degen_calc = (kval > $signed(KW'(DEGEN_KMAX))) ? 1'b0 : (lhs < rhs);
    degen_eff = sts.det_bad || degen_calc;
    ratio_eff = sts.det_bad ? RATIO_SAT : ratio;
    str_eff = degen_eff || (ratio_eff > max_stretch_ratio);
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      stretched <= str_eff;
      degenerate <= degen_eff;
      stretch_ratio <= str_eff ? ratio_eff : RATIO_ONE;
    end
  end

endmodule

// ===== design/tmsc_ctrl.sv =====
// Controller of the triangle map stretch check: sequences normalize, MAC,
// square roots and divide, and owns the stream handshakes.
// Depends on tmsc_pkg.
module tmsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  input  logic                s_mapped,
  output logic                s_ready,
  output logic                m_valid,
  input  logic                m_ready,
  output tmsc_pkg::tmsc_cmd_t cmd,
  input  tmsc_pkg::tmsc_sts_t sts
);
  import tmsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_MAC, S_DISC, S_SQRT_D, S_QLOAD, S_SQRT_S, S_DIV, S_DONE
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;

  assign s_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take_src = s_valid && !s_mapped;
        cmd.take_map = s_valid && s_mapped;
      end
      S_NORM: cmd.norm_step = 1'b1;
      S_MAC: begin
        cmd.mac_step = 1'b1;
        cmd.mac_idx = cnt[MAC_IDX_W-1:0];
      end
      S_DISC: cmd.sqrt_init = !sts.det_bad;
      S_SQRT_D: cmd.sqrt_step = 1'b1;
      S_QLOAD: begin
        cmd.q_load = 1'b1;
        cmd.sqrt_init = 1'b1;
        cmd.sqrt_sel = 1'b1;
      end
      S_SQRT_S: begin
        cmd.sqrt_step = 1'b1;
        cmd.div_init = (cnt == '0);
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_bit = DIV_IDX_W'(DIV_BITS - 1) - cnt[DIV_IDX_W-1:0];
      end
      S_DONE: cmd.res_load = !m_valid || m_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      m_valid <= 1'b0;
    end else begin
      if (cmd.res_load) m_valid <= 1'b1;
      else if (m_valid && m_ready) m_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (s_valid && s_mapped) state <= S_NORM;
        end
        S_NORM: if (sts.norm_done) state <= S_MAC;
        S_MAC: begin
          if (cnt == CNT_W'(MAC_STEPS - 1)) begin
            cnt <= '0;
            state <= S_DISC;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DISC: state <= sts.det_bad ? S_DONE : S_SQRT_D;
        S_SQRT_D: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SQRT_ITERS - 1)) state <= S_QLOAD;
        end
        S_QLOAD: begin
          cnt <= '0;
          state <= S_SQRT_S;
        end
        S_SQRT_S: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SQRT_ITERS - 1)) state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_BITS - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!m_valid || m_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_map_starts: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_ready && s_mapped |=> state == S_NORM)
    else $error("mapped item did not start evaluation");

  a_degen_skip: assert property (@(posedge clk) disable iff (rst)
    state == S_DISC && sts.det_bad |=> state == S_DONE)
    else $error("zero determinant did not skip to result");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> $past(state) == S_DIV || $past(state) == S_SQRT_S)
    else $error("divide entered out of sequence");

  a_res_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> m_valid)
    else $error("loaded result not presented");

endmodule

// ===== design/triangle_map_stretch_check_top.sv =====
// Triangle map stretch check, top level.
// Takes a source triangle, then a mapped triangle, and reports how much the affine
// map between them stretches. A mapped item is first normalized by a shift of at
// most COORD_WIDTH-14 bits per triangle; the evaluation then runs the 35-step MAC
// sequence on the single 32x32 multiplier, the two 64-step square roots on the
// shared root unit and the 16-step divider. A pair with a non-positive Gram
// determinant skips the roots and divide. Input is accepted only between
// evaluations; a finished result waits in the output register without blocking
// acceptance of the next item. Depends on tmsc_pkg, tmsc_ctrl and tmsc_datapath.
module triangle_map_stretch_check_top #(
  parameter int COORD_WIDTH = tmsc_pkg::COORD_WIDTH_DEF,
  parameter int IN_W = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  logic [IN_W-1:0]             s_axis_tdata,
  // is_mapped
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // stretched, stretch_ratio[15:0], degenerate, zero pad
  output logic [23:0]                 m_axis_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tmsc_pkg::*;

  tmsc_cmd_t cmd;
  tmsc_sts_t sts;
  logic [15:0] max_stretch_ratio;
  logic stretched, degenerate;
  logic [15:0] stretch_ratio;
  logic reg_hit;

  assign pready = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_MAX_STRETCH);
  assign prdata = reg_hit ? {16'b0, max_stretch_ratio} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_stretch_ratio <= MAX_STRETCH_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_stretch_ratio <= pwdata[15:0];
    end
  end

  tmsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_mapped (s_axis_tuser),
    .s_ready  (s_axis_tready),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tmsc_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .coords            (s_axis_tdata[9*COORD_WIDTH-1:0]),
    .max_stretch_ratio (max_stretch_ratio),
    .stretched         (stretched),
    .stretch_ratio     (stretch_ratio),
    .degenerate        (degenerate)
  );

  assign m_axis_tdata = {6'b0, degenerate, stretch_ratio, stretched};

endmodule

// ===== dv/triangle_map_stretch_check_top_tb.sv =====
// Testbench for triangle_map_stretch_check_top: directed triangle pairs, then random
// pairs and noise under several ratio limits, each result checked in order against a
// stored or fixed-point predicted result. Depends on tmsc_pkg and the top level.
`timescale 1ns / 100ps

module triangle_map_stretch_check_top_tb;
  import tmsc_pkg::*;

  localparam int WDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 250;

  typedef longint edge_vec_t [6];
  typedef struct {
    logic        stretched;
    logic [15:0] ratio;
    logic        degen;
  } stretch_res_t;
  typedef struct {
    bit           mapped;
    logic [287:0] verts;
    bit           known;
    stretch_res_t res;
  } tri_row_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [287:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  stretch_res_t pending_res[$];
  tri_row_t rows[$];
  edge_vec_t src_edge;
  logic [15:0] ratio_limit;
  int errors;
  int idle_cycles;
  int stall_left;

  triangle_map_stretch_check_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned norm_shift(edge_vec_t e);
    longint unsigned m;
    int unsigned s;
    m = 0;
    s = 0;
    for (int i = 0; i < 6; i++) m |= (e[i] < 0) ? -e[i] : e[i];
    while (s < 63 && (m >> s) >= (64'd1 << NORM_BITS)) s++;
    return s;
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return r;
  endfunction

  function automatic edge_vec_t edges_of(logic [287:0] d);
    longint p [9];
    edge_vec_t e;
    for (int i = 0; i < 9; i++) p[i] = longint'($signed(d[32*i +: 32]));
    for (int i = 0; i < 3; i++) begin
      e[i] = p[3+i] - p[i];
      e[3+i] = p[6+i] - p[i];
    end
    return e;
  endfunction

  function automatic stretch_res_t predict_stretch(edge_vec_t me);
    edge_vec_t a, b;
    int unsigned ss, sm;
    longint g11, g12, g22, c11, c12, c22, adet, cdet, tr;
    logic [127:0] t2, ac, ac4, disc, target, lhs, rhs;
    logic [63:0] q, s, c;
    logic [15:0] ratio;
    logic degen;
    int k;
    stretch_res_t r;
    ss = norm_shift(src_edge);
    sm = norm_shift(me);
    for (int i = 0; i < 6; i++) begin
      a[i] = (src_edge[i] < 0) ? -((-src_edge[i]) >> ss) : (src_edge[i] >> ss);
      b[i] = (me[i] < 0) ? -((-me[i]) >> sm) : (me[i] >> sm);
    end
    g11 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
    g12 = a[0]*a[3] + a[1]*a[4] + a[2]*a[5];
    g22 = a[3]*a[3] + a[4]*a[4] + a[5]*a[5];
    c11 = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
    c12 = b[0]*b[3] + b[1]*b[4] + b[2]*b[5];
    c22 = b[3]*b[3] + b[4]*b[4] + b[5]*b[5];
    adet = c11*c22 - c12*c12;
    cdet = g11*g22 - g12*g12;
    tr = c22*g11 - 2*c12*g12 + c11*g22;
    if (tr < 0) tr = 0;
    ratio = RATIO_SAT;
    if (adet <= 0 || cdet <= 0) begin
      degen = 1'b1;
    end else begin
      t2 = {64'd0, 64'(tr)} * {64'd0, 64'(tr)};
      ac = {64'd0, 64'(adet)} * {64'd0, 64'(cdet)};
      ac4 = ac << 2;
      disc = (ac4 <= t2) ? t2 - ac4 : '0;
      q = 64'(tr) + isqrt(disc);
      s = isqrt(ac);
      target = {64'd0, q} << RATIO_FRAC_SHIFT;
      ratio = '0;
      for (int bt = 15; bt >= 0; bt--) begin
        c = 64'(ratio) | (64'd1 << bt);
        if ({64'd0, c} * {64'd0, s} <= target) ratio = c[15:0];
      end
      k = 2*int'(ss) - 2*int'(sm) + DEGEN_EXP;
      lhs = {64'd0, 64'(cdet)};
      rhs = {64'd0, q};
      if (k >= 0) degen = (k > DEGEN_KMAX) ? 1'b0 : ((lhs << k) < rhs);
      else degen = lhs < (rhs << (-k));
    end
    r.degen = degen;
    r.stretched = degen || (ratio > ratio_limit);
    r.ratio = r.stretched ? ratio : RATIO_ONE;
    return r;
  endfunction

  function automatic logic [287:0] tri_pack(int x0, int y0, int z0, int x1, int y1, int z1,
                                            int x2, int y2, int z2);
    return {x2, y2, z2, x1, y1, z1, x0, y0, z0} == 0 ? '0 :
           {z2, y2, x2, z1, y1, x1, z0, y0, x0};
  endfunction

  function automatic void add_row(bit mapped, logic [287:0] verts, bit known,
                                  stretch_res_t res);
    tri_row_t r;
    r.mapped = mapped;
    r.verts = verts;
    r.known = known;
    r.res = res;
    rows.insert(rows.size(), r);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return int'($urandom);
      1: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $signed($urandom) >>> $urandom_range(8, 20);
    endcase
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_triangle(bit mapped, logic [287:0] verts, bit known,
                               stretch_res_t res);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mapped;
    s_axis_tdata <= verts;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (!mapped) src_edge = edges_of(verts);
    else pending_res.insert(pending_res.size(),
                            known ? res : predict_stretch(edges_of(verts)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ratio_limit(logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_MAX_STRETCH, 2'b00};
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ratio_limit = v;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= rand_gap();
    end
  end

  always @(posedge clk) begin
    stretch_res_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_r = pending_res.pop_front();
        if (m_axis_tdata[0] !== exp_r.stretched || m_axis_tdata[16:1] !== exp_r.ratio ||
            m_axis_tdata[17] !== exp_r.degen) begin
          $display("%0t: mismatch stretched/ratio/degenerate exp %b/%0d/%b got %b/%0d/%b",
                   $time, exp_r.stretched, exp_r.ratio, exp_r.degen,
                   m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[17]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAIL triangle_map_stretch_check_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stretch_res_t none, degen_res, unity_res;
    logic [287:0] src, mp;
    logic [15:0] limits [5];
    int u, big;
    errors = 0;
    idle_cycles = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ratio_limit = MAX_STRETCH_RESET;
    for (int i = 0; i < 6; i++) src_edge[i] = 0;
    none = '{1'b0, 16'd0, 1'b0};
    degen_res = '{1'b1, RATIO_SAT, 1'b1};
    unity_res = '{1'b0, RATIO_ONE, 1'b0};
    u = 1 << 16;
    big = 1 << 30;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // mapped item before any source
    add_row(1, tri_pack(0, 0, 0, u, 0, 0, 0, u, 0), 1, degen_res);
    add_row(0, tri_pack(0, 0, 0, u, 0, 0, 0, u, 0), 0, none);
    add_row(1, tri_pack(0, 0, 0, u, 0, 0, 0, u, 0), 1, unity_res);
    add_row(1, tri_pack(0, 0, 0, u, u, u, 2*u, 2*u, 2*u), 1, degen_res);
    add_row(1, tri_pack(5, 7, 9, 100*u, 7, 9, 5, u, 9), 0, none);
    add_row(0, tri_pack(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                        32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF), 0, none);
    add_row(1, tri_pack(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                        32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h80000000, 32'h80000000), 0, none);
    add_row(0, tri_pack(0, 0, 0, big, 0, 0, 0, big, 0), 0, none);
    add_row(1, tri_pack(0, 0, 0, 1, 0, 0, 0, 1, 0), 0, none);
    add_row(1, tri_pack(-u, -u, 0, -u, -u, 0, 0, 0, 0), 1, degen_res);
    add_row(0, tri_pack(3, 3, 3, 3, 3, 3, 3, 3, 3), 0, none);
    add_row(1, tri_pack(0, 0, 0, u, 0, 0, 0, u, 0), 1, degen_res);
    add_row(0, tri_pack(0, 0, 0, u, 0, 0, 0, 0, u), 0, none);
    add_row(1, tri_pack(0, 0, 0, 0, 3*u, 0, -u, 0, 0), 0, none);
    add_row(1, tri_pack(0, 0, 0, u, 0, 0, u/2, u, 0), 0, none);
    foreach (rows[i]) send_triangle(rows[i].mapped, rows[i].verts, rows[i].known, rows[i].res);
    wait_drained();

    limits = '{16'd0, 16'hFFFF, 16'(MAX_STRETCH_RESET), 16'd256, 16'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      write_ratio_limit(limits[ph]);
      for (int n = 0; n < 270; ) begin
        if ($urandom_range(0, 9) == 0) begin
          for (int i = 0; i < 9; i++) mp[32*i +: 32] = rand_coord();
          send_triangle($urandom_range(0, 1), mp, 0, none);
          n++;
        end else begin
          for (int i = 0; i < 9; i++) src[32*i +: 32] = rand_coord();
          send_triangle(0, src, 0, none);
          if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 9; i++) mp[32*i +: 32] = rand_coord();
          end else begin
            for (int i = 0; i < 9; i++)
              mp[32*i +: 32] = 32'((longint'($signed(src[32*i +: 32])) *
                                    $urandom_range(1, 40)) >>> 3);
          end
          send_triangle(1, mp, 0, none);
          n += 2;
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS triangle_map_stretch_check_top");
    end else begin
      $display("FAIL triangle_map_stretch_check_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tmsc_pkg.sv
design/tmsc_datapath.sv
design/tmsc_ctrl.sv
design/triangle_map_stretch_check_top.sv
dv/triangle_map_stretch_check_top_tb.sv
